// ===== rtl/core/lpsd_pkg.sv =====
// Shared types and constants for the length-prefixed sample deframer.
// Used by the parser, the scaler, the register block and the top level.
// No dependencies.
package lpsd_pkg;

    localparam int MAX_CHANNELS   = 512;
    localparam int GAIN_FRAC_BITS = 16;

    // Field widths of the stream and the result.
    localparam int BYTE_W    = 8;
    localparam int RAW_W     = 16;
    localparam int LEN_W     = 31;
    localparam int CHCNT_W   = 10;
    localparam int POS_W     = 9;
    localparam int OFFSET_W  = 16;
    localparam int GAIN_W    = 24;
    localparam int VALUE_W   = 25;
    localparam int FRAME_B_W = CHCNT_W + 1;

    // Arithmetic widths of the scaler.
    localparam int DIFF_W = RAW_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;

    // Channel count after clamping; never above what POS_W can index.
    localparam int CHAN_LIMIT = (MAX_CHANNELS < 512) ? MAX_CHANNELS : 512;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CHCNT_W-1:0]  CHANNEL_COUNT_RST = CHCNT_W'(512);
    localparam logic [OFFSET_W-1:0] SAMPLE_OFFSET_RST = OFFSET_W'(32768);
    localparam logic [GAIN_W-1:0]   SAMPLE_GAIN_RST   = GAIN_W'(65536);

    typedef enum logic [1:0] {
        REG_CHANNEL_COUNT = 2'd0,
        REG_SAMPLE_OFFSET = 2'd1,
        REG_SAMPLE_GAIN   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CHCNT_W-1:0]  channel_count;
        logic [OFFSET_W-1:0] sample_offset;
        logic [GAIN_W-1:0]   sample_gain;
    } cfg_t;

    // One raw sample handed from the parser to the scaler.
    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic [POS_W-1:0] pos;
        logic             frame_end;
        logic             chunk_end;
    } smp_t;

endpackage

// ===== rtl/core/lpsd_regs.sv =====
// Configuration registers behind an APB-style port.
// Depends on lpsd_pkg for the register map and the cfg_t bundle.
module lpsd_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpsd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lpsd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lpsd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output lpsd_pkg::cfg_t                 cfg
);
    import lpsd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_CHANNEL_COUNT: cfg_next.channel_count = pwdata[CHCNT_W-1:0];
                REG_SAMPLE_OFFSET: cfg_next.sample_offset = pwdata[OFFSET_W-1:0];
                REG_SAMPLE_GAIN:   cfg_next.sample_gain   = pwdata[GAIN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CHANNEL_COUNT: prdata = APB_DATA_W'(cfg_reg.channel_count);
            REG_SAMPLE_OFFSET: prdata = APB_DATA_W'(cfg_reg.sample_offset);
            REG_SAMPLE_GAIN:   prdata = APB_DATA_W'(cfg_reg.sample_gain);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_count <= CHANNEL_COUNT_RST;
            cfg_reg.sample_offset <= SAMPLE_OFFSET_RST;
            cfg_reg.sample_gain   <= SAMPLE_GAIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/lpsd_parser.sv =====
// Byte-level chunk parser: header assembly, payload accounting and sample pairing.
// Depends on lpsd_pkg; hands whole raw samples to the scaler through a one-entry register.
module lpsd_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lpsd_pkg::BYTE_W-1:0]   s_in_byte,
    input  logic [lpsd_pkg::CHCNT_W-1:0]  channel_count,
    output logic                          smp_valid,
    input  logic                          smp_ready,
    output lpsd_pkg::smp_t                smp
);
    import lpsd_pkg::*;

    logic [1:0]        header_count_reg, header_count_next;
    logic [23:0]       header_word_reg, header_word_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic              text_chunk_reg, text_chunk_next;
    logic              tail_skip_reg, tail_skip_next;
    logic [BYTE_W-1:0] low_byte_reg, low_byte_next;
    logic              byte_phase_reg, byte_phase_next;
    logic [POS_W-1:0]  channel_pos_reg, channel_pos_next;
    logic              smp_valid_reg, smp_valid_next;
    smp_t              smp_reg, smp_next;

    logic                 in_fire;
    logic                 emit;
    logic [CHCNT_W-1:0]   chans;
    logic [CHCNT_W-1:0]   last_pos;
    logic [FRAME_B_W-1:0] frame_bytes;
    logic [LEN_W-1:0]     bytes_dec;
    logic [31:0]          full_header;
    logic                 fend;

    assign s_ready   = !smp_valid_reg || smp_ready;
    assign in_fire   = s_valid && s_ready;
    assign smp_valid = smp_valid_reg;
    assign smp       = smp_reg;

    always_comb begin
        if (channel_count == '0) begin
            chans = CHCNT_W'(1);
        end else if (channel_count > CHCNT_W'(CHAN_LIMIT)) begin
            chans = CHCNT_W'(CHAN_LIMIT);
        end else begin
            chans = channel_count;
        end
    end

    assign last_pos    = chans - CHCNT_W'(1);
    assign frame_bytes = {chans, 1'b0};
    assign bytes_dec   = bytes_left_reg - LEN_W'(1);
    assign full_header = {s_in_byte, header_word_reg};
    assign fend        = {1'b0, channel_pos_reg} >= last_pos;

    always_comb begin
        header_count_next = header_count_reg;
        header_word_next  = header_word_reg;
        bytes_left_next   = bytes_left_reg;
        text_chunk_next   = text_chunk_reg;
        tail_skip_next    = tail_skip_reg;
        low_byte_next     = low_byte_reg;
        byte_phase_next   = byte_phase_reg;
        channel_pos_next  = channel_pos_reg;
        emit              = 1'b0;
        smp_next          = smp_reg;

        if (in_fire) begin
            if (bytes_left_reg == '0) begin
                // Header byte; the fourth one completes the length word.
                if (header_count_reg == 2'd3) begin
                    bytes_left_next   = full_header[LEN_W-1:0];
                    text_chunk_next   = full_header[31];
                    header_word_next  = '0;
                    header_count_next = '0;
                    tail_skip_next    = 1'b0;
                    byte_phase_next   = 1'b0;
                    channel_pos_next  = '0;
                end else begin
                    header_word_next[header_count_reg*8 +: 8] = s_in_byte;
                    header_count_next = header_count_reg + 2'd1;
                end
            end else begin
                bytes_left_next = bytes_dec;
                if (!text_chunk_reg && !tail_skip_reg) begin
                    if (!byte_phase_reg) begin
                        // At a frame start, drop the payload if a whole frame no longer fits.
                        if (channel_pos_reg == '0 &&
                            bytes_left_reg < LEN_W'(frame_bytes)) begin
                            tail_skip_next = 1'b1;
                        end else begin
                            low_byte_next   = s_in_byte;
                            byte_phase_next = 1'b1;
                        end
                    end else begin
                        byte_phase_next     = 1'b0;
                        emit                = 1'b1;
                        smp_next.raw        = {s_in_byte, low_byte_reg};
                        smp_next.pos        = channel_pos_reg;
                        smp_next.frame_end  = fend;
                        smp_next.chunk_end  = fend && (bytes_dec < LEN_W'(frame_bytes));
                        channel_pos_next    = fend ? '0 : channel_pos_reg + POS_W'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        if (in_fire) begin
            smp_valid_next = emit;
        end else if (smp_ready) begin
            smp_valid_next = 1'b0;
        end else begin
            smp_valid_next = smp_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_count_reg <= '0;
            header_word_reg  <= '0;
            bytes_left_reg   <= '0;
            text_chunk_reg   <= 1'b0;
            tail_skip_reg    <= 1'b0;
            low_byte_reg     <= '0;
            byte_phase_reg   <= 1'b0;
            channel_pos_reg  <= '0;
            smp_valid_reg    <= 1'b0;
        end else begin
            header_count_reg <= header_count_next;
            header_word_reg  <= header_word_next;
            bytes_left_reg   <= bytes_left_next;
            text_chunk_reg   <= text_chunk_next;
            tail_skip_reg    <= tail_skip_next;
            low_byte_reg     <= low_byte_next;
            byte_phase_reg   <= byte_phase_next;
            channel_pos_reg  <= channel_pos_next;
            smp_valid_reg    <= smp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        smp_reg <= smp_next;
    end

endmodule

// ===== rtl/core/lpsd_scaler.sv =====
// Offset removal, gain multiply, floor shift and saturation into the result register.
// Depends on lpsd_pkg for widths and the smp_t record.
module lpsd_scaler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                smp_valid,
    output logic                                smp_ready,
    input  lpsd_pkg::smp_t                      smp,
    input  logic [lpsd_pkg::OFFSET_W-1:0]       sample_offset,
    input  logic [lpsd_pkg::GAIN_W-1:0]         sample_gain,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lpsd_pkg::VALUE_W-1:0] m_sample_value,
    output logic [lpsd_pkg::POS_W-1:0]          m_channel_index,
    output logic                                m_frame_end,
    output logic                                m_chunk_end
);
    import lpsd_pkg::*;

    localparam logic signed [PROD_W-1:0] OUT_MAX = PROD_W'((1 << (VALUE_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] OUT_MIN = -PROD_W'(1 << (VALUE_W - 1));

    logic                       m_valid_reg, m_valid_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic [POS_W-1:0]           index_reg;
    logic                       frame_end_reg;
    logic                       chunk_end_reg;

    logic                       load;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   shifted;

    assign smp_ready = !m_valid_reg || m_ready;
    assign load      = smp_valid && smp_ready;

    assign diff    = $signed({1'b0, smp.raw}) - $signed({1'b0, sample_offset});
    assign gain_s  = $signed({1'b0, sample_gain});
    assign prod    = PROD_W'(diff) * PROD_W'(gain_s);
    // Arithmetic shift gives the floor for negative products.
    assign shifted = prod >>> GAIN_FRAC_BITS;

    always_comb begin
        if (shifted > OUT_MAX) begin
            value_next = OUT_MAX[VALUE_W-1:0];
        end else if (shifted < OUT_MIN) begin
            value_next = OUT_MIN[VALUE_W-1:0];
        end else begin
            value_next = shifted[VALUE_W-1:0];
        end
    end

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            value_reg     <= value_next;
            index_reg     <= smp.pos;
            frame_end_reg <= smp.frame_end;
            chunk_end_reg <= smp.chunk_end;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sample_value  = value_reg;
    assign m_channel_index = index_reg;
    assign m_frame_end     = frame_end_reg;
    assign m_chunk_end     = chunk_end_reg;

endmodule

// ===== rtl/core/length_prefixed_sample_deframer.sv =====
// Length-prefixed sample deframer, top level.
// Depends on lpsd_pkg, lpsd_regs, lpsd_parser and lpsd_scaler.
//
// The s_ channel takes the chunked byte stream, one byte per request. Each chunk
// opens with a 4-byte little-endian header: bit 31 marks a text chunk, the low
// 31 bits give the payload length. Text payloads are dropped; binary payloads
// are paired into little-endian 16-bit samples, offset, scaled by the Q8.16 gain
// and sent on the m_ channel with channel index, frame end and chunk end marks.
// A trailing partial frame or odd byte is dropped.
//
// Throughput is one byte per cycle while s_ready is high, two bytes per result.
// After its high byte is accepted, a result passes the parser's sample register,
// which feeds the multiplier, and then the result register at its output.
// The next byte is accepted while a result waits to be taken; when the
// receiver stalls, one sample more is held in the sample register, and s_ready
// drops only once both registers are full. Reset clears the parser to expect a
// header and loads the default channel count, offset and gain. The user must
// write registers over the APB port while idle; the block does not enforce it.
module length_prefixed_sample_deframer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lpsd_pkg::BYTE_W-1:0]         s_in_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lpsd_pkg::VALUE_W-1:0] m_sample_value,
    output logic [lpsd_pkg::POS_W-1:0]          m_channel_index,
    output logic                                m_frame_end,
    output logic                                m_chunk_end,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpsd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lpsd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lpsd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import lpsd_pkg::*;

    cfg_t cfg;
    smp_t smp;
    logic smp_valid;
    logic smp_ready;

    lpsd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lpsd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .channel_count (cfg.channel_count),
        .smp_valid     (smp_valid),
        .smp_ready     (smp_ready),
        .smp           (smp)
    );

    lpsd_scaler u_scaler (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .smp_valid       (smp_valid),
        .smp_ready       (smp_ready),
        .smp             (smp),
        .sample_offset   (cfg.sample_offset),
        .sample_gain     (cfg.sample_gain),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_value  (m_sample_value),
        .m_channel_index (m_channel_index),
        .m_frame_end     (m_frame_end),
        .m_chunk_end     (m_chunk_end)
    );

endmodule

// ===== rtl/core/lpsd_checker.sv =====
// Port-level checks for the length-prefixed sample deframer, bound to the top level.
// Depends only on the handshake and mark ports of length_prefixed_sample_deframer.
module lpsd_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_frame_end,
    input logic m_chunk_end
);

    // A result held back by the receiver stays offered.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn while stalled");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A chunk can only end on the last channel of a frame.
    a_chunk_on_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_chunk_end |-> m_frame_end)
        else $error("chunk end without frame end");

    // With the result register empty, the input side is never stalled.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind length_prefixed_sample_deframer lpsd_checker u_lpsd_checker (.*);
